// File: sv/gwlp_pkg.sv
`default_nettype none
package gwlp_pkg;

    localparam int DIM       = 32;
    localparam int ADDR_W    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int IDX_W     = 5;
    localparam int POS_W     = 32;
    localparam int FIT_W     = 64;
    localparam int STEP_W    = 18;
    localparam int RND_W     = 16;
    localparam int TAKE_W    = 3;
    localparam int CFG_IDX_W = 1;

    localparam int X_W        = 59;
    localparam int S_W        = X_W + 2;
    localparam int T_W        = S_W - 16;
    localparam int U_W        = 48;
    localparam int DIV_STEPS  = U_W / 8;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'b1;

    localparam logic OP_OFFER  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam int LANE_ALPHA = 0;
    localparam int LANE_BETA  = 1;
    localparam int LANE_DELTA = 2;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [FIT_W-1:0] t_fit;
    typedef logic [ADDR_W-1:0]       t_addr;

    typedef struct packed {
        logic              opcode;
        logic [IDX_W-1:0]  element_index;
        t_fit              fitness;
        t_pos              position_value;
        logic [STEP_W-1:0] step_size;
        logic [RND_W-1:0]  rand_alpha_a;
        logic [RND_W-1:0]  rand_alpha_c;
        logic [RND_W-1:0]  rand_beta_a;
        logic [RND_W-1:0]  rand_beta_c;
        logic [RND_W-1:0]  rand_delta_a;
        logic [RND_W-1:0]  rand_delta_c;
    } t_in_item;

    typedef struct packed {
        t_pos              new_position;
        t_fit              best_score;
        logic [TAKE_W-1:0] leaders_taken;
    } t_out_item;

    typedef struct packed {
        logic [TAKE_W-1:0] we;
        t_addr             addr;
        t_pos              data;
    } t_ram_wr;

    function automatic logic signed [U_W-1:0] clip_value(
        input logic signed [U_W-1:0] v,
        input t_pos lo,
        input t_pos hi
    );
        logic signed [U_W-1:0] lo_x;
        logic signed [U_W-1:0] hi_x;
        logic signed [U_W-1:0] r;
        lo_x = U_W'(lo);
        hi_x = U_W'(hi);
        r = v;
        if (r < lo_x) r = lo_x;
        if (r > hi_x) r = hi_x;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/gwlp_in_if.sv
`default_nettype none
interface gwlp_in_if import gwlp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// File: sv/gwlp_out_if.sv
`default_nettype none
interface gwlp_out_if import gwlp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// File: sv/gwlp_leader_ram.sv
`default_nettype none
module gwlp_leader_ram import gwlp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ram_wr                       i_wr,
    input  t_addr                         i_raddr,
    output logic [TAKE_W-1:0][POS_W-1:0]  o_rdata
);

    for (genvar l = 0; l < TAKE_W; l++) begin : g_lane
        logic [POS_W-1:0] r_mem [DIM];
        logic [DIM-1:0]   r_valid;
        logic [POS_W-1:0] r_rd;
        logic             r_rd_valid;

        always_ff @(posedge i_clk) begin
            if (i_wr.we[l]) begin
                r_mem[i_wr.addr] <= i_wr.data;
            end
            r_rd <= r_mem[i_raddr];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid    <= '0;
                r_rd_valid <= 1'b0;
            end else begin
                if (i_wr.we[l]) begin
                    r_valid[i_wr.addr] <= 1'b1;
                end
                r_rd_valid <= r_valid[i_raddr];
            end
        end

        assign o_rdata[l] = r_rd_valid ? r_rd : '0;
    end

endmodule
`default_nettype wire

// File: sv/gwlp_term.sv
`default_nettype none
module gwlp_term import gwlp_pkg::*; (
    input  logic                    i_clk,
    input  t_pos                    i_lead,
    input  t_pos                    i_pos,
    input  logic [STEP_W-1:0]       i_step,
    input  logic [RND_W-1:0]        i_ra,
    input  logic [RND_W-1:0]        i_rc,
    output logic signed [X_W-1:0]   o_term
);

    logic [STEP_W+RND_W-1:0]   w_ar;
    logic signed [49:0]        w_cprod;
    logic [STEP_W+RND_W:0]     r_aprod;
    logic signed [49:0]        r_cprod;
    t_pos                      r_lead1;
    t_pos                      r_pos1;
    logic [STEP_W-1:0]         r_step1;

    logic [STEP_W+RND_W+1:0]   w_asum;
    logic signed [20:0]        w_amul;
    logic signed [50:0]        w_diff;
    logic [50:0]               w_mag;
    logic [51:0]               w_dsum;
    logic signed [20:0]        r_amul;
    logic [35:0]               r_dist;
    t_pos                      r_lead2;

    logic signed [57:0]        w_prod;

    assign w_ar    = i_step * i_ra;
    assign w_cprod = $signed({1'b0, i_rc, 1'b0}) * i_lead;

    assign w_asum = {1'b0, r_aprod} + 36'd32768;
    assign w_amul = $signed({1'b0, w_asum[35:16]}) - $signed({3'b0, r_step1});
    assign w_diff = $signed({r_cprod[49], r_cprod})
                  - $signed({{3{r_pos1[31]}}, r_pos1, 16'b0});
    assign w_mag  = w_diff[50] ? 51'(-w_diff) : 51'(w_diff);
    assign w_dsum = {1'b0, w_mag} + 52'd32768;

    assign w_prod = r_amul * $signed({1'b0, r_dist});

    always_ff @(posedge i_clk) begin
        r_aprod <= {w_ar, 1'b0};
        r_cprod <= w_cprod;
        r_lead1 <= i_lead;
        r_pos1  <= i_pos;
        r_step1 <= i_step;

        r_amul  <= w_amul;
        r_dist  <= w_dsum[51:16];
        r_lead2 <= r_lead1;

        o_term  <= $signed({{11{r_lead2[31]}}, r_lead2, 16'b0})
                 - $signed({w_prod[57], w_prod});
    end

endmodule
`default_nettype wire

// File: sv/gwlp_div3.sv
`default_nettype none
module gwlp_div3 import gwlp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [U_W-1:0] i_dividend,
    output logic [U_W-1:0] o_quotient,
    output logic           o_done
);

    logic [U_W-1:0]       r_work;
    logic [1:0]           r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [9:0]           w_x;
    logic [19:0]          w_mul;
    logic [7:0]           w_qd;
    logic [9:0]           w_r;

    assign w_x   = {r_rem, r_work[U_W-1 -: 8]};
    assign w_mul = 20'(w_x) * 20'd683;
    assign w_qd  = w_mul[18:11];
    assign w_r   = w_x - 10'(w_qd) * 10'd3;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= 2'd0;
        end else if (r_busy) begin
            r_work <= {r_work[U_W-9:0], w_qd};
            r_rem  <= w_r[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_work;
    assign o_done     = r_done;

endmodule
`default_nettype wire

// File: sv/grey_wolf_leader_and_position_update_core.sv
`default_nettype none
// One item at a time. An offer item passes from acceptance through the commit
// of leader scores and the memory write, then the output load. An update item
// passes through one read of the leader memory, the three-stage leader term
// pipeline, the sum, a divide by three that retires one byte per cycle and
// flags completion in the cycle after its last byte, then the output load,
// which waits until the output register is free. The input is ready again the
// cycle after the output load. The leader vectors sit in a memory with one
// lane per leader and a valid bit per entry, so reset takes effect at once
// with no clearing pass. A new item is taken while a finished result still
// waits in the output register.
module grey_wolf_leader_and_position_update_core import gwlp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data,
    gwlp_in_if.sink              i_in,
    gwlp_out_if.source           o_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_OFFER, S_RD, S_P1, S_P2, S_P3, S_SUM, S_DIV, S_DONE
    } t_state;

    t_state             r_state;
    t_in_item           r_item;
    t_pos               r_lower;
    t_pos               r_upper;
    t_fit               r_alpha_best;
    t_fit               r_beta_best;
    t_fit               r_delta_best;
    logic [TAKE_W-1:0]  r_take;
    t_pos               r_res;
    logic [TAKE_W-1:0]  r_taken;
    t_out_item          r_out;
    logic               r_out_valid;

    logic                          w_ok;
    logic                          w_first;
    logic                          w_take_a;
    logic                          w_take_b;
    logic                          w_take_d;
    logic [TAKE_W-1:0]             w_flags;
    logic signed [U_W-1:0]         w_offer_clip;
    t_ram_wr                       w_wr;
    logic [TAKE_W-1:0][POS_W-1:0]  w_rdata;
    t_pos                          w_lead [TAKE_W];
    logic signed [X_W-1:0]         w_term [TAKE_W];
    logic signed [S_W-1:0]         w_sum;
    logic [U_W-1:0]                w_u;
    logic [U_W-1:0]                w_quot;
    logic                          w_div_done;
    logic signed [U_W-1:0]         w_q;
    logic signed [U_W-1:0]         w_upd_clip;
    logic                          w_slot;
    logic [RND_W-1:0]              w_ra [TAKE_W];
    logic [RND_W-1:0]              w_rc [TAKE_W];

    localparam logic [U_W-1:0] DIV_OFS  = U_W'(3) << T_W;
    localparam logic [U_W-1:0] QUOT_OFS = U_W'(1) << T_W;

    assign w_ok    = int'(r_item.element_index) < DIM;
    assign w_first = (r_item.element_index == '0);

    assign w_take_a = r_item.fitness < r_alpha_best;
    assign w_take_b = !w_take_a && (r_item.fitness > r_alpha_best)
                    && (r_item.fitness < r_beta_best);
    assign w_take_d = !w_take_a && !w_take_b && (r_item.fitness > r_alpha_best)
                    && (r_item.fitness > r_beta_best) && (r_item.fitness < r_delta_best);
    assign w_flags  = w_first ? {w_take_d, w_take_b, w_take_a} : r_take;

    assign w_offer_clip = clip_value(U_W'(r_item.position_value), r_lower, r_upper);

    assign w_wr.we   = (r_state == S_OFFER && w_ok) ? w_flags : '0;
    assign w_wr.addr = ADDR_W'(r_item.element_index);
    assign w_wr.data = w_offer_clip[POS_W-1:0];

    gwlp_leader_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_raddr (ADDR_W'(r_item.element_index)),
        .o_rdata (w_rdata)
    );

    assign w_ra[LANE_ALPHA] = r_item.rand_alpha_a;
    assign w_rc[LANE_ALPHA] = r_item.rand_alpha_c;
    assign w_ra[LANE_BETA]  = r_item.rand_beta_a;
    assign w_rc[LANE_BETA]  = r_item.rand_beta_c;
    assign w_ra[LANE_DELTA] = r_item.rand_delta_a;
    assign w_rc[LANE_DELTA] = r_item.rand_delta_c;

    for (genvar l = 0; l < TAKE_W; l++) begin : g_term
        assign w_lead[l] = w_ok ? t_pos'(w_rdata[l]) : '0;
        gwlp_term u_term (
            .i_clk  (i_clk),
            .i_lead (w_lead[l]),
            .i_pos  (r_item.position_value),
            .i_step (r_item.step_size),
            .i_ra   (w_ra[l]),
            .i_rc   (w_rc[l]),
            .o_term (w_term[l])
        );
    end

    assign w_sum = S_W'(w_term[LANE_ALPHA]) + S_W'(w_term[LANE_BETA])
                 + S_W'(w_term[LANE_DELTA]) + S_W'(98304);
    assign w_u   = U_W'($signed(w_sum[S_W-1:16])) + DIV_OFS;

    gwlp_div3 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SUM),
        .i_dividend (w_u),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    assign w_q        = $signed(w_quot - QUOT_OFS);
    assign w_upd_clip = clip_value(w_q, r_lower, r_upper);
    assign w_slot     = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_lower      <= t_pos'(32'h8000_0000);
            r_upper      <= t_pos'(32'h7FFF_FFFF);
            r_alpha_best <= t_fit'(64'h7FFF_FFFF_FFFF_FFFF);
            r_beta_best  <= t_fit'(64'h7FFF_FFFF_FFFF_FFFF);
            r_delta_best <= t_fit'(64'h7FFF_FFFF_FFFF_FFFF);
            r_take       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOWER: r_lower <= t_pos'(i_cfg_data);
                    CFG_UPPER: r_upper <= t_pos'(i_cfg_data);
                    default: ;
                endcase
            end
            if (r_state == S_DONE && w_slot) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_item  <= i_in.item;
                        r_state <= (i_in.item.opcode == OP_OFFER) ? S_OFFER : S_RD;
                    end
                end
                S_OFFER: begin
                    if (w_first) begin
                        if (w_take_a) r_alpha_best <= r_item.fitness;
                        if (w_take_b) r_beta_best  <= r_item.fitness;
                        if (w_take_d) r_delta_best <= r_item.fitness;
                        r_take <= w_flags;
                    end
                    r_res   <= w_offer_clip[POS_W-1:0];
                    r_taken <= w_flags;
                    r_state <= S_DONE;
                end
                S_RD:  r_state <= S_P1;
                S_P1:  r_state <= S_P2;
                S_P2:  r_state <= S_P3;
                S_P3:  r_state <= S_SUM;
                S_SUM: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_res   <= w_upd_clip[POS_W-1:0];
                        r_taken <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot) begin
                        r_out.new_position  <= r_res;
                        r_out.best_score    <= r_alpha_best;
                        r_out.leaders_taken <= r_taken;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divide finished outside its wait state");

    a_take_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_take))
        else $error("offered agent taken by more than one leader");

    a_alpha_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OFFER && w_first && w_take_a) |=>
        (r_alpha_best == $past(r_item.fitness)))
        else $error("alpha score not updated on take");

    a_no_write_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_OFFER) |-> (w_wr.we == '0))
        else $error("leader memory written outside offer commit");
`endif

endmodule
`default_nettype wire

// File: tb/gwlp_checker.sv
`default_nettype none
module gwlp_checker import gwlp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data,
    gwlp_in_if                   i_in,
    gwlp_out_if                  i_out,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_pos            pack_alpha [DIM];
    t_pos            pack_beta  [DIM];
    t_pos            pack_delta [DIM];
    longint          score_alpha;
    longint          score_beta;
    longint          score_delta;
    logic [2:0]      take_set;
    longint          bound_lo;
    longint          bound_hi;
    t_out_item       result_q [$];

    assign o_pending = result_q.size();

    function automatic longint clamp_to_bounds(longint v);
        if (v < bound_lo) v = bound_lo;
        if (v > bound_hi) v = bound_hi;
        return v;
    endfunction

    function automatic longint wolf_term(longint lead, longint p, longint a,
                                         longint ra, longint rc);
        longint amul;
        longint diff;
        longint span;
        amul = ((2 * a * ra + 32768) >>> 16) - a;
        diff = 2 * rc * lead - p * 65536;
        if (diff < 0) diff = -diff;
        span = (diff + 32768) >>> 16;
        return lead * 65536 - amul * span;
    endfunction

    function automatic t_out_item wolf_step(t_in_item it);
        t_out_item r;
        t_pos      p32;
        longint    p;
        longint    f;
        longint    res;
        longint    s;
        int        idx;
        logic [2:0] fl;
        p32 = it.position_value;
        p   = p32;
        f   = it.fitness;
        idx = it.element_index;
        r.leaders_taken = '0;
        if (it.opcode == OP_OFFER) begin
            res = clamp_to_bounds(p);
            if (idx == 0) begin
                fl = '0;
                if (f < score_alpha) begin
                    score_alpha = f;
                    fl[0] = 1'b1;
                end
                if (f > score_alpha && f < score_beta) begin
                    score_beta = f;
                    fl[1] = 1'b1;
                end
                if (f > score_alpha && f > score_beta && f < score_delta) begin
                    score_delta = f;
                    fl[2] = 1'b1;
                end
                take_set = fl;
            end
            if (idx < DIM) begin
                if (take_set[0]) pack_alpha[idx] = t_pos'(res);
                if (take_set[1]) pack_beta[idx]  = t_pos'(res);
                if (take_set[2]) pack_delta[idx] = t_pos'(res);
            end
            r.leaders_taken = take_set;
        end else begin
            s = wolf_term(idx < DIM ? longint'(pack_alpha[idx]) : 0, p,
                          it.step_size, it.rand_alpha_a, it.rand_alpha_c)
              + wolf_term(idx < DIM ? longint'(pack_beta[idx]) : 0, p,
                          it.step_size, it.rand_beta_a, it.rand_beta_c)
              + wolf_term(idx < DIM ? longint'(pack_delta[idx]) : 0, p,
                          it.step_size, it.rand_delta_a, it.rand_delta_c);
            s = s + 98304;
            if (s >= 0) s = s / 196608;
            else s = -((-s + 196607) / 196608);
            res = clamp_to_bounds(s);
        end
        r.new_position = t_pos'(res);
        r.best_score   = score_alpha;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_pos      lim;
        if (!i_rst_n) begin
            for (int k = 0; k < DIM; k++) begin
                pack_alpha[k] = '0;
                pack_beta[k]  = '0;
                pack_delta[k] = '0;
            end
            score_alpha = 64'h7fff_ffff_ffff_ffff;
            score_beta  = 64'h7fff_ffff_ffff_ffff;
            score_delta = 64'h7fff_ffff_ffff_ffff;
            take_set = '0;
            bound_lo = -64'sd2147483648;
            bound_hi = 64'sd2147483647;
            result_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                lim = i_cfg_data;
                if (i_cfg_index == CFG_LOWER) bound_lo = lim;
                else if (i_cfg_index == CFG_UPPER) bound_hi = lim;
            end
            if (i_in.valid && i_in.ready)
                result_q.push_back(wolf_step(i_in.item));
            if (i_out.valid && i_out.ready) begin
                if (result_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("tb: unexpected item %h", i_out.item);
                    o_errors <= o_errors + 1;
                end else begin
                    want = result_q.pop_front();
                    if (want.new_position !== i_out.item.new_position ||
                        want.best_score !== i_out.item.best_score ||
                        want.leaders_taken !== i_out.item.leaders_taken) begin
                        if (o_errors < 10)
                            $display("tb: mismatch pos %h/%h score %h/%h take %h/%h",
                                     want.new_position, i_out.item.new_position,
                                     want.best_score, i_out.item.best_score,
                                     want.leaders_taken, i_out.item.leaders_taken);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
    import gwlp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 3000000;
    localparam longint FIT_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam longint FIT_MIN = 64'h8000_0000_0000_0000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LOWER;
    logic [POS_W-1:0]     i_cfg_data = '0;
    int                   errors;
    int                   pending;
    int                   n_sent = 0;
    int                   n_recv = 0;
    int                   cycles = 0;
    int                   tx_idle_pct = 0;
    int                   rx_stall_pct = 0;
    int                   rx_hold = 0;

    gwlp_in_if  in_ch ();
    gwlp_out_if out_ch ();

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.item   = '0;
        out_ch.ready = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    grey_wolf_leader_and_position_update_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    gwlp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) n_recv <= n_recv + 1;
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (n_recv != n_sent) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic send(t_in_item it);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
        gap = 0;
        if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 400)) - 200 <<< 16
                            | $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic t_in_item make_item(logic op, int idx, longint fit,
                                           logic [31:0] pos);
        t_in_item it;
        it.opcode         = op;
        it.element_index  = IDX_W'(idx);
        it.fitness        = fit;
        it.position_value = pos;
        case ($urandom_range(0, 9))
            0: it.step_size = '0;
            1: it.step_size = 18'd131072;
            default: it.step_size = STEP_W'($urandom_range(0, 131072));
        endcase
        it.rand_alpha_a = RND_W'($urandom);
        it.rand_alpha_c = RND_W'($urandom);
        it.rand_beta_a  = RND_W'($urandom);
        it.rand_beta_c  = RND_W'($urandom);
        it.rand_delta_a = RND_W'($urandom);
        it.rand_delta_c = RND_W'($urandom);
        return it;
    endfunction

    function automatic longint pick_fit();
        case ($urandom_range(0, 19))
            0: return FIT_MAX;
            1: return FIT_MIN;
            2, 3, 4: return {$urandom, $urandom};
            default: return longint'($signed($urandom_range(0, 4000)) - 2000) <<< 24;
        endcase
    endfunction

    task automatic directed();
        t_in_item it;
        send(make_item(OP_OFFER, 3, 0, 32'h0001_0000));
        send(make_item(OP_UPDATE, 0, 0, 32'h7fff_ffff));
        send(make_item(OP_OFFER, 0, FIT_MAX, 32'h8000_0000));
        send(make_item(OP_OFFER, 0, 64'sd100, 32'h0002_0000));
        send(make_item(OP_OFFER, 31, 64'sd100, 32'h7fff_ffff));
        send(make_item(OP_OFFER, 0, 64'sd200, 32'hfffe_0000));
        send(make_item(OP_OFFER, 31, 64'sd200, 32'h8000_0000));
        send(make_item(OP_OFFER, 0, 64'sd300, 32'h0005_8000));
        send(make_item(OP_OFFER, 0, 64'sd150, 32'h0003_0000));
        send(make_item(OP_OFFER, 0, 64'sd100, 32'h0009_0000));
        send(make_item(OP_OFFER, 0, FIT_MIN, 32'hffff_ffff));
        for (int k = 0; k < 6; k++) begin
            it = make_item(OP_UPDATE, k % 2 ? 31 : 0, FIT_MAX, pick_pos());
            it.step_size = k < 3 ? 18'd0 : 18'd131072;
            {it.rand_alpha_a, it.rand_alpha_c, it.rand_beta_a,
             it.rand_beta_c, it.rand_delta_a, it.rand_delta_c} =
                k % 3 == 0 ? '0 : k % 3 == 1 ? '1
                           : {6{RND_W'($urandom_range(0, 65535))}};
            send(it);
        end
        send(make_item(OP_UPDATE, 5, 0, 32'h8000_0000));
        send(make_item(OP_UPDATE, 31, 0, 32'h7fff_ffff));
    endtask

    task automatic random_items(int count);
        int done;
        int len;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                               {$urandom, $urandom}, $urandom));
                done++;
            end else begin
                len = $urandom_range(0, 9) == 0 ? 31 : $urandom_range(0, 5);
                send(make_item(OP_OFFER, 0, pick_fit(), pick_pos()));
                for (int e = 1; e <= len; e++)
                    send(make_item(OP_OFFER, e, pick_fit(), pick_pos()));
                done += len + 1;
                len = $urandom_range(1, 4);
                for (int e = 0; e < len; e++)
                    send(make_item(OP_UPDATE, $urandom_range(0, 31), pick_fit(),
                                   pick_pos()));
                done += len;
            end
        end
    endtask

    initial begin
        logic [31:0] lo;
        logic [31:0] hi;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0, 5: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
                1: begin lo = 32'hff9c_0000; hi = 32'h0064_0000; end
                2: begin lo = 32'h0005_0000; hi = 32'hfffb_0000; end
                3: begin lo = 32'h0; hi = 32'h0; end
                default: begin
                    lo = -$urandom_range(1, 1 << 24);
                    hi = $urandom_range(1, 1 << 24);
                end
            endcase
            write_reg(CFG_LOWER, lo);
            write_reg(CFG_UPPER, hi);
            tx_idle_pct  = (ph % 4 == 1) ? 59 : (ph % 4 == 3) ? 32 : 0;
            rx_stall_pct = (ph % 4 == 2) ? 59 : (ph % 4 == 3) ? 32 : 0;
            if (ph == 0) directed();
            if (ph == 2) rx_hold = 300;
            random_items(90);
            if (ph == 1) begin
                in_ch.valid <= 1'b0;
                while (n_recv != n_sent) @(posedge i_clk);
            end
            random_items(90);
            in_ch.valid <= 1'b0;
            drain();
        end
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
